@@ rtl/acr_pkg.sv @@
// Shared constants and types for the age counter replacement table.
package acr_pkg;

   localparam int NUM_ENTRIES = 8;
   localparam int KEY_WIDTH   = 32;
   localparam int AGE_WIDTH   = 16;
   localparam int IDX_WIDTH   = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
   localparam int LEN_WIDTH   = 21;
   localparam int IN_KEY_WIDTH  = 32;
   localparam int OUT_IDX_WIDTH = 6;

   localparam logic [LEN_WIDTH-1:0] SIZE_LIMIT_RESET = LEN_WIDTH'(1049000);

   localparam logic KIND_LOOKUP = 1'b0;
   localparam logic KIND_INSERT = 1'b1;

   typedef logic [KEY_WIDTH-1:0]     tag_type;
   typedef logic [AGE_WIDTH-1:0]     age_type;
   typedef logic [LEN_WIDTH-1:0]     len_type;
   typedef logic [IDX_WIDTH-1:0]     idx_type;
   typedef logic [OUT_IDX_WIDTH-1:0] out_idx_type;
   typedef logic [IN_KEY_WIDTH-1:0]  in_key_type;

   typedef struct packed {
      tag_type tag;
      age_type age;
      len_type length;
   } entry_type;

endpackage

@@ rtl/acr_req_if.sv @@
// Request channel: one lookup or insert word per handshake.
interface acr_req_if;
   logic                 valid;
   logic                 ready;
   logic                 kind;
   acr_pkg::in_key_type  key;
   acr_pkg::len_type     object_length;

   modport source (output valid, kind, key, object_length, input ready);
   modport sink   (input valid, kind, key, object_length, output ready);
endinterface

@@ rtl/acr_rsp_if.sv @@
// Response channel: one result word per request.
interface acr_rsp_if;
   logic                 valid;
   logic                 ready;
   logic                 hit;
   logic                 stored;
   acr_pkg::out_idx_type entry_index;
   acr_pkg::len_type     hit_length;

   modport source (output valid, hit, stored, entry_index, hit_length, input ready);
   modport sink   (input valid, hit, stored, entry_index, hit_length, output ready);
endinterface

@@ rtl/age_counter_cache_replacement.sv @@
// Fully associative tag table with saturating age counters and oldest-entry replacement.
// The single read port of the entry memory walks one entry per cycle during the scan, with
// ages written back behind it on a lookup.
// A rejected insert skips the scan. One request is in flight at a time; the next is
// accepted once the response word has been loaded into the output register.
// Reset: synchronous, active high; clears all valid bits and loads size_limit with 1049000.
module age_counter_cache_replacement (
   input  logic                 clock,
   input  logic                 reset,
   acr_req_if.sink              req_ch,
   acr_rsp_if.source            rsp_ch,
   input  logic                 csr_wr_en,
   input  acr_pkg::len_type     csr_wr_data
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   localparam acr_pkg::idx_type LAST_IDX = acr_pkg::idx_type'(acr_pkg::NUM_ENTRIES - 1);

   state_type state_ff, state_in;
   logic [acr_pkg::NUM_ENTRIES-1:0] valid_bits_ff, valid_bits_in;
   acr_pkg::len_type  size_limit_ff, size_limit_in;
   logic              issue_ff, issue_in;
   logic              pend_ff, pend_in;
   logic              rsp_valid_ff, rsp_valid_in;

   acr_pkg::idx_type  cnt_ff, cnt_in;
   acr_pkg::idx_type  pend_idx_ff, pend_idx_in;
   logic              free_found_ff, free_found_in;
   acr_pkg::idx_type  free_idx_ff, free_idx_in;
   acr_pkg::age_type  best_age_ff, best_age_in;
   acr_pkg::idx_type  victim_ff, victim_in;
   logic              kind_ff, kind_in;
   acr_pkg::tag_type  key_ff, key_in;
   acr_pkg::len_type  len_ff, len_in;
   logic              hit_ff, hit_in;
   logic              stored_ff, stored_in;
   acr_pkg::idx_type  res_idx_ff, res_idx_in;
   acr_pkg::len_type  hlen_ff, hlen_in;
   logic              rsp_hit_ff, rsp_hit_in;
   logic              rsp_stored_ff, rsp_stored_in;
   acr_pkg::out_idx_type rsp_idx_ff, rsp_idx_in;
   acr_pkg::len_type  rsp_len_ff, rsp_len_in;

   acr_pkg::entry_type entry_mem_ff [acr_pkg::NUM_ENTRIES];
   acr_pkg::entry_type rd_data_ff;
   logic               rd_en;
   acr_pkg::idx_type   rd_addr;
   logic               wr_en;
   acr_pkg::idx_type   wr_addr;
   acr_pkg::entry_type wr_data;

   logic             rsp_free;
   logic             scan_done;
   acr_pkg::idx_type victim_sel;

   assign req_ch.ready       = (state_ff == ST_IDLE);
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.hit         = rsp_hit_ff;
   assign rsp_ch.stored      = rsp_stored_ff;
   assign rsp_ch.entry_index = rsp_idx_ff;
   assign rsp_ch.hit_length  = rsp_len_ff;

   assign rsp_free   = !rsp_valid_ff || rsp_ch.ready;
   assign scan_done  = (state_ff == ST_SCAN) && !issue_ff && !pend_ff;
   assign victim_sel = free_found_ff ? free_idx_ff : victim_ff;

   always_comb begin
      state_in      = state_ff;
      valid_bits_in = valid_bits_ff;
      size_limit_in = csr_wr_en ? csr_wr_data : size_limit_ff;
      issue_in      = issue_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      cnt_in        = cnt_ff;
      pend_idx_in   = pend_idx_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      best_age_in   = best_age_ff;
      victim_in     = victim_ff;
      kind_in       = kind_ff;
      key_in        = key_ff;
      len_in        = len_ff;
      hit_in        = hit_ff;
      stored_in     = stored_ff;
      res_idx_in    = res_idx_ff;
      hlen_in       = hlen_ff;
      rsp_hit_in    = rsp_hit_ff;
      rsp_stored_in = rsp_stored_ff;
      rsp_idx_in    = rsp_idx_ff;
      rsp_len_in    = rsp_len_ff;
      rd_en         = 1'b0;
      rd_addr       = cnt_ff;
      wr_en         = 1'b0;
      wr_addr       = pend_idx_ff;
      wr_data       = rd_data_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               kind_in       = req_ch.kind;
               key_in        = acr_pkg::tag_type'(req_ch.key);
               len_in        = req_ch.object_length;
               hit_in        = 1'b0;
               stored_in     = 1'b0;
               res_idx_in    = '0;
               hlen_in       = '0;
               cnt_in        = '0;
               issue_in      = 1'b1;
               pend_in       = 1'b0;
               free_found_in = 1'b0;
               free_idx_in   = '0;
               best_age_in   = '0;
               victim_in     = '0;
               if (req_ch.kind == acr_pkg::KIND_INSERT &&
                   req_ch.object_length > size_limit_ff) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            pend_in = 1'b0;
            if (issue_ff) begin
               if (valid_bits_ff[cnt_ff]) begin
                  rd_en       = 1'b1;
                  pend_in     = 1'b1;
                  pend_idx_in = cnt_ff;
                  if (cnt_ff == LAST_IDX) begin
                     issue_in = 1'b0;
                  end else begin
                     cnt_in = cnt_ff + 1'b1;
                  end
               end else begin
                  issue_in      = 1'b0;
                  free_found_in = 1'b1;
                  free_idx_in   = cnt_ff;
               end
            end
            if (pend_ff) begin
               if (kind_ff == acr_pkg::KIND_LOOKUP) begin
                  wr_en = 1'b1;
                  if (rd_data_ff.tag == key_ff) begin
                     wr_data.age = '0;
                     hit_in      = 1'b1;
                     res_idx_in  = pend_idx_ff;
                     hlen_in     = rd_data_ff.length;
                  end else if (rd_data_ff.age != '1) begin
                     wr_data.age = rd_data_ff.age + 1'b1;
                  end
               end else if (rd_data_ff.age > best_age_ff) begin
                  best_age_in = rd_data_ff.age;
                  victim_in   = pend_idx_ff;
               end
            end
            if (scan_done) begin
               state_in = ST_FINISH;
               if (kind_ff == acr_pkg::KIND_INSERT) begin
                  wr_en                     = 1'b1;
                  wr_addr                   = victim_sel;
                  wr_data.tag               = key_ff;
                  wr_data.age               = '0;
                  wr_data.length            = len_ff;
                  valid_bits_in[victim_sel] = 1'b1;
                  stored_in                 = 1'b1;
                  res_idx_in                = victim_sel;
               end
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_hit_in    = hit_ff;
               rsp_stored_in = stored_ff;
               rsp_idx_in    = acr_pkg::out_idx_type'(res_idx_ff);
               rsp_len_in    = hlen_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         valid_bits_ff <= '0;
         size_limit_ff <= acr_pkg::SIZE_LIMIT_RESET;
         issue_ff      <= 1'b0;
         pend_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         valid_bits_ff <= valid_bits_in;
         size_limit_ff <= size_limit_in;
         issue_ff      <= issue_in;
         pend_ff       <= pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff        <= cnt_in;
      pend_idx_ff   <= pend_idx_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      best_age_ff   <= best_age_in;
      victim_ff     <= victim_in;
      kind_ff       <= kind_in;
      key_ff        <= key_in;
      len_ff        <= len_in;
      hit_ff        <= hit_in;
      stored_ff     <= stored_in;
      res_idx_ff    <= res_idx_in;
      hlen_ff       <= hlen_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_stored_ff <= rsp_stored_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_len_ff    <= rsp_len_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= entry_mem_ff[rd_addr];
      end
   end

   a_pend_in_scan: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (state_ff == ST_SCAN))
      else $error("read data pending outside the scan");

   a_insert_sets_valid: assert property (@(posedge clock) disable iff (reset)
      (scan_done && kind_ff == acr_pkg::KIND_INSERT) |=> valid_bits_ff[$past(victim_sel)])
      else $error("written entry not marked valid");

   a_valid_grows: assert property (@(posedge clock) disable iff (reset)
      ($past(valid_bits_ff) & ~valid_bits_ff) == '0)
      else $error("valid bit dropped");

   a_hit_excl_stored: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_hit_ff && rsp_stored_ff))
      else $error("response reports both hit and store");

endmodule

@@ tb/acr_answer_checker.sv @@
// Checker for the age counter table: predicts each answer word and compares the response channel.
module acr_answer_checker
   import acr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   acr_req_if      req_ch,
   acr_rsp_if      rsp_ch,
   input  logic    csr_wr_en,
   input  len_type csr_wr_data,
   output int      pending,
   output int      errors
);

   typedef struct packed {
      logic        hit;
      logic        stored;
      out_idx_type entry_index;
      len_type     hit_length;
   } table_answer_type;

   logic             live [NUM_ENTRIES];
   tag_type          tags [NUM_ENTRIES];
   age_type          ages [NUM_ENTRIES];
   len_type          lens [NUM_ENTRIES];
   len_type          size_cap;
   table_answer_type answers_due [$];
   int               error_count = 0;

   assign errors = error_count;

   function automatic table_answer_type table_answer(logic kind, in_key_type key, len_type len);
      table_answer_type ans;
      tag_type          tag;
      int               victim;
      bit               found;
      ans = '0;
      tag = tag_type'(key);
      if (kind == KIND_LOOKUP) begin
         for (int i = 0; i < NUM_ENTRIES; i++) begin
            if (!live[i]) break;
            if (tags[i] != tag) begin
               if (ages[i] != '1) ages[i] = ages[i] + 1'b1;
            end else begin
               ages[i] = '0;
               ans.hit = 1'b1;
               ans.entry_index = out_idx_type'(i);
               ans.hit_length = lens[i];
            end
         end
      end else if (len <= size_cap) begin
         victim = 0;
         found = 1'b0;
         for (int i = 0; i < NUM_ENTRIES; i++) begin
            if (!found) begin
               if (!live[i]) begin
                  victim = i;
                  found = 1'b1;
               end else if (ages[i] > ages[victim]) begin
                  victim = i;
               end
            end
         end
         live[victim] = 1'b1;
         tags[victim] = tag;
         lens[victim] = len;
         ages[victim] = '0;
         ans.stored = 1'b1;
         ans.entry_index = out_idx_type'(victim);
      end
      return ans;
   endfunction

   function automatic void compare_field(string field, len_type want, len_type got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      table_answer_type want;
      if (reset) begin
         for (int i = 0; i < NUM_ENTRIES; i++) begin
            live[i] = 1'b0;
            tags[i] = '0;
            ages[i] = '0;
            lens[i] = '0;
         end
         size_cap = SIZE_LIMIT_RESET;
         answers_due.delete();
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (answers_due.size() == 0) begin
               $display("%0t: unexpected word, expected none, actual %0h/%0h/%0h/%0h", $time,
                        rsp_ch.hit, rsp_ch.stored, rsp_ch.entry_index, rsp_ch.hit_length);
               error_count++;
            end else begin
               want = answers_due.pop_front();
               compare_field("hit", len_type'(want.hit), len_type'(rsp_ch.hit));
               compare_field("stored", len_type'(want.stored), len_type'(rsp_ch.stored));
               compare_field("entry_index", len_type'(want.entry_index),
                             len_type'(rsp_ch.entry_index));
               compare_field("hit_length", want.hit_length, rsp_ch.hit_length);
            end
         end
         if (req_ch.valid && req_ch.ready)
            answers_due.push_back(table_answer(req_ch.kind, req_ch.key, req_ch.object_length));
         if (csr_wr_en) size_cap = csr_wr_data;
      end
      pending <= answers_due.size();
   end

endmodule

@@ tb/tb_age_counter_cache_replacement.sv @@
// Testbench top for the age counter table: request and register stimulus, and the verdict.
module tb_age_counter_cache_replacement;
   import acr_pkg::*;

   localparam int         POOL_SIZE     = 12;
   localparam int         SETTLE_CYCLES = NUM_ENTRIES + 4;
   localparam in_key_type KEY_A = 32'hA5A5_5A5A;
   localparam in_key_type KEY_B = 32'h5A5A_A5A5;
   localparam in_key_type KEY_C = 32'h1234_5678;
   localparam in_key_type KEY_D = 32'h8000_0000;
   localparam in_key_type KEY_E = 32'h0000_0001;
   localparam in_key_type KEY_F = 32'h0F0F_F0F0;

   logic       clock = 1'b0;
   logic       reset;
   logic       csr_wr_en;
   len_type    csr_wr_data;
   int         pending;
   int         errors;
   bit         quiet;
   len_type    size_cap;
   in_key_type key_pool [POOL_SIZE];

   acr_req_if req_ch ();
   acr_rsp_if rsp_ch ();

   age_counter_cache_replacement dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   acr_answer_checker answer_check (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .pending     (pending),
      .errors      (errors)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) rsp_ch.ready <= quiet || ($urandom_range(0, 99) >= 7);

   task automatic send_word(input logic kind, input in_key_type key, input len_type len);
      while (!quiet && $urandom_range(0, 99) < 7) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.kind <= kind;
      req_ch.key <= key;
      req_ch.object_length <= len;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic await_answers();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   task automatic settle();
      await_answers();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(input len_type value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      size_cap = value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic send_random();
      logic       kind;
      in_key_type key;
      len_type    len;
      int         pick;
      kind = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 9);
      if (pick < 6) key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      else if (pick == 6) key = '0;
      else if (pick == 7) key = '1;
      else key = $urandom;
      if (kind == KIND_INSERT && pick >= 8) key_pool[$urandom_range(0, POOL_SIZE - 1)] = key;
      pick = $urandom_range(0, 9);
      case (pick)
         0, 1, 2, 3: len = len_type'($urandom_range(0, size_cap));
         4:          len = size_cap;
         5:          len = len_type'(size_cap + 1'b1);
         6:          len = '0;
         7:          len = '1;
         default:    len = len_type'($urandom);
      endcase
      send_word(kind, key, len);
   endtask

   initial begin
      reset <= 1'b1;
      csr_wr_en <= 1'b0;
      csr_wr_data <= '0;
      req_ch.valid <= 1'b0;
      req_ch.kind <= KIND_LOOKUP;
      req_ch.key <= '0;
      req_ch.object_length <= '0;
      quiet = 1'b0;
      size_cap = SIZE_LIMIT_RESET;
      foreach (key_pool[i]) key_pool[i] = $urandom;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      send_word(KIND_LOOKUP, '0, '0);
      send_word(KIND_INSERT, KEY_A, '0);
      send_word(KIND_INSERT, KEY_B, SIZE_LIMIT_RESET);
      send_word(KIND_INSERT, KEY_C, len_type'(SIZE_LIMIT_RESET + 1));
      // hold entry 0 young while entry 1 ages
      quiet = 1'b1;
      repeat (40) send_word(KIND_LOOKUP, KEY_A, len_type'($urandom));
      quiet = 1'b0;
      send_word(KIND_INSERT, '0, '0);
      send_word(KIND_INSERT, '1, SIZE_LIMIT_RESET);
      send_word(KIND_INSERT, KEY_C, 21'd100);
      send_word(KIND_INSERT, KEY_C, 21'd200);
      send_word(KIND_INSERT, KEY_D, 21'd300);
      send_word(KIND_INSERT, KEY_E, 21'd400);
      send_word(KIND_INSERT, KEY_F, 21'd500);
      send_word(KIND_LOOKUP, KEY_C, '0);
      send_word(KIND_LOOKUP, '0, '1);
      send_word(KIND_LOOKUP, '1, '0);
      send_word(KIND_LOOKUP, KEY_B, '0);
      send_word(KIND_LOOKUP, KEY_F, '0);
      send_word(KIND_INSERT, KEY_B, '1);
      settle();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0:       write_limit('0);
            1:       write_limit('1);
            2:       write_limit(len_type'($urandom_range(1, (1 << LEN_WIDTH) - 2)));
            default: write_limit(len_type'(1000));
         endcase
         quiet = (phase == 1);
         repeat (140) begin
            send_random();
            if ($urandom_range(0, 49) == 0) await_answers();
         end
         quiet = 1'b0;
         settle();
      end

      if (errors == 0 && pending == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
